### src/etg_pkg.sv
package etg_pkg;

  localparam int IDX_BITS   = 13;
  localparam int SINE_BITS  = 15;
  localparam int SAMPLE_W   = 16;
  localparam int VOL_BITS   = 17;
  localparam int GS_BITS    = 30;
  localparam int FRAC_SHIFT = 16;

  localparam logic [IDX_BITS-1:0]   TOTAL_MAX  = 13'd8191;
  localparam logic [VOL_BITS-1:0]   FULL_GAIN  = 17'd65536;
  localparam logic [GS_BITS-1:0]    TONE_SCALE = 30'd12000;
  localparam logic [SINE_BITS-1:0]  SAMPLE_MAX = 15'd32767;
  localparam longint                HALF_PI_Q30 = 64'sd1686629713;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [1:0] CAT_DEFAULT     = 2'd0;
  localparam logic [1:0] CAT_OPPORTUNITY = 2'd1;
  localparam logic [1:0] CAT_WARNING     = 2'd2;

  typedef struct packed {
    logic start;
    logic tick;
    logic mul1;
    logic mul2;
    logic div1;
    logic div2;
    logic div3;
    logic div4;
    logic load;
  } etg_cmd_t;

  typedef struct packed {
    logic active;
  } etg_status_t;

endpackage

### src/etg_ctrl.sv
module etg_ctrl
  import etg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_kind,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  etg_status_t status,
  output etg_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DIV1,
    S_DIV2,
    S_DIV3,
    S_DIV4,
    S_PUT
  } state_t;

  state_t state;
  logic   accept;
  logic   load;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = (state == S_PUT) && (!out_valid || out_ready);

  assign cmd.start = accept && (in_kind == CMD_START);
  assign cmd.tick  = accept && (in_kind == CMD_TICK);
  assign cmd.mul1  = (state == S_MUL1);
  assign cmd.mul2  = (state == S_MUL2);
  assign cmd.div1  = (state == S_DIV1);
  assign cmd.div2  = (state == S_DIV2);
  assign cmd.div3  = (state == S_DIV3);
  assign cmd.div4  = (state == S_DIV4);
  assign cmd.load  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.tick) begin
            state <= status.active ? S_MUL1 : S_PUT;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_DIV1;
        S_DIV1: state <= S_DIV2;
        S_DIV2: state <= S_DIV3;
        S_DIV3: state <= S_DIV4;
        S_DIV4: state <= S_PUT;
        S_PUT: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_tone_tick_latency: assert property (@(posedge clk) disable iff (rst)
    cmd.tick && status.active |-> ##7 (state == S_PUT))
    else $error("tone request did not reach the output step in time");

  a_idle_tick_direct: assert property (@(posedge clk) disable iff (rst)
    cmd.tick && !status.active |=> (state == S_PUT))
    else $error("idle request did not go straight to the output step");

  a_put_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) && out_valid && !out_ready |=> (state == S_PUT))
    else $error("result overwrote a pending output");

endmodule

### src/etg_datapath.sv
module etg_datapath
  import etg_pkg::*;
#(
  parameter int SAMPLE_RATE     = 44100,
  parameter int FADE_LEN        = 220,
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  etg_cmd_t            cmd,
  input  logic [1:0]          category,
  input  logic [VOL_BITS-1:0] volume,
  output etg_status_t         status,
  output logic [SAMPLE_W-1:0] sample,
  output logic                playing,
  output logic                last
);

  localparam int QuarterLen = 2 ** (SINE_TABLE_BITS - 2);
  localparam int AddrBits   = SINE_TABLE_BITS - 1;
  localparam int EBits      = $clog2(FADE_LEN + 1);
  localparam int P1Bits     = SINE_BITS + EBits;
  localparam int P2Bits     = P1Bits + GS_BITS;
  localparam int QBits      = SINE_BITS + $clog2(FADE_LEN);
  localparam int RecipBits  = QBits + 1;
  localparam int ProdBits   = QBits + RecipBits;

  localparam longint unsigned Limit = 64'd32768 * 64'(FADE_LEN);
  localparam longint unsigned Recip = (64'd1 << QBits) / 64'(FADE_LEN);

  localparam longint unsigned StepLo =
    ((64'd440 << PHASE_BITS) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
  localparam longint unsigned StepMid =
    ((64'd660 << PHASE_BITS) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
  localparam longint unsigned StepHi =
    ((64'd880 << PHASE_BITS) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);

  localparam int TotLo0  = SAMPLE_RATE * 80 / 1000;
  localparam int TotMid0 = SAMPLE_RATE * 110 / 1000;
  localparam int TotHi0  = SAMPLE_RATE * 140 / 1000;
  localparam int TotLo   = (TotLo0 > 8191) ? 8191 : TotLo0;
  localparam int TotMid  = (TotMid0 > 8191) ? 8191 : TotMid0;
  localparam int TotHi   = (TotHi0 > 8191) ? 8191 : TotHi0;

  logic [SINE_BITS-1:0] quarter_rom [QuarterLen+1];

  for (genvar q = 0; q <= QuarterLen; q++) begin : g_rom
    localparam longint X  = (longint'(q) * HALF_PI_Q30) / QuarterLen;
    localparam longint X2 = (X * X) >>> 30;
    localparam longint T1 = ((X * X2) >>> 30) / 6;
    localparam longint T2 = ((T1 * X2) >>> 30) / 20;
    localparam longint T3 = ((T2 * X2) >>> 30) / 42;
    localparam longint T4 = ((T3 * X2) >>> 30) / 72;
    localparam longint T5 = ((T4 * X2) >>> 30) / 110;
    localparam longint T6 = ((T5 * X2) >>> 30) / 156;
    localparam longint S  = X - T1 + T2 - T3 + T4 - T5 + T6;
    localparam longint SP = (S < 0) ? 64'sd0 : S;
    localparam longint V0 = (SP * 32767 + 64'sd536870912) >>> 30;
    localparam longint V  = (V0 > 32767) ? 64'sd32767 : V0;
    assign quarter_rom[q] = SINE_BITS'(V);
  end

  logic                       active;
  logic [PHASE_BITS-1:0]      phase;
  logic [PHASE_BITS-1:0]      phase_step;
  logic [IDX_BITS-1:0]        sample_index;
  logic [IDX_BITS-1:0]        sample_total;
  logic [GS_BITS-1:0]         gs;

  logic [SINE_BITS-1:0]       rom_q;
  logic                       neg;
  logic [EBits-1:0]           env;
  logic [P1Bits-1:0]          p1;
  logic [P2Bits-1:0]          p2;
  logic                       over;
  logic [QBits-1:0]           qv;
  logic [SINE_BITS-1:0]       est;
  logic [QBits-1:0]           estf;
  logic [SINE_BITS-1:0]       quot;

  logic [SINE_TABLE_BITS-1:0] tab_idx;
  logic [1:0]                 quad;
  logic [AddrBits-2:0]        quad_off;
  logic [AddrBits-1:0]        rom_addr;
  logic [IDX_BITS-1:0]        remain;
  logic [IDX_BITS-1:0]        env_min;
  logic [EBits-1:0]           env_next;
  logic [VOL_BITS-1:0]        vol_sat;
  logic [PHASE_BITS-1:0]      step_sel;
  logic [IDX_BITS-1:0]        total_sel;
  logic [P2Bits-1:0]          scaled;
  logic [ProdBits-1:0]        recip_prod;
  logic [QBits-1:0]           div_rem;
  logic [SINE_BITS-1:0]       mag;
  logic [IDX_BITS-1:0]        index_inc;
  logic                       fin;

  assign status.active = active;

  assign tab_idx  = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign quad     = tab_idx[SINE_TABLE_BITS-1 -: 2];
  assign quad_off = tab_idx[SINE_TABLE_BITS-3:0];
  assign rom_addr = quad[0] ? (AddrBits'(QuarterLen) - {1'b0, quad_off}) : {1'b0, quad_off};

  assign remain   = (sample_index < sample_total) ?
                    (sample_total - sample_index - IDX_BITS'(1)) : '0;
  assign env_min  = (remain < sample_index) ? remain : sample_index;
  assign env_next = (env_min > IDX_BITS'(FADE_LEN)) ? EBits'(FADE_LEN) : EBits'(env_min);

  assign vol_sat  = (volume > FULL_GAIN) ? FULL_GAIN : volume;

  always_comb begin
    unique case (category)
      CAT_OPPORTUNITY: begin
        step_sel  = PHASE_BITS'(StepMid);
        total_sel = IDX_BITS'(TotMid);
      end
      CAT_WARNING: begin
        step_sel  = PHASE_BITS'(StepHi);
        total_sel = IDX_BITS'(TotHi);
      end
      default: begin
        step_sel  = PHASE_BITS'(StepLo);
        total_sel = IDX_BITS'(TotLo);
      end
    endcase
  end

  assign scaled     = p2 >> FRAC_SHIFT;
  assign recip_prod = ProdBits'(qv) * ProdBits'(RecipBits'(Recip));
  assign div_rem    = qv - estf;
  assign mag        = over ? SAMPLE_MAX : quot;
  assign index_inc  = sample_index + IDX_BITS'(1);
  assign fin        = (index_inc >= sample_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      phase        <= '0;
      phase_step   <= '0;
      sample_index <= '0;
      sample_total <= '0;
      gs           <= '0;
    end else begin
      if (cmd.start) begin
        gs           <= GS_BITS'(vol_sat) * TONE_SCALE;
        phase        <= '0;
        phase_step   <= step_sel;
        sample_index <= '0;
        sample_total <= total_sel;
        active       <= (vol_sat != '0) && (total_sel != '0);
      end else if (cmd.load && active) begin
        phase        <= phase + phase_step;
        sample_index <= index_inc;
        if (fin) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      rom_q <= quarter_rom[rom_addr];
      neg   <= quad[1];
      env   <= env_next;
    end
    if (cmd.mul1) begin
      p1 <= P1Bits'(rom_q) * P1Bits'(env);
    end
    if (cmd.mul2) begin
      p2 <= P2Bits'(p1) * P2Bits'(gs);
    end
    if (cmd.div1) begin
      over <= (scaled >= P2Bits'(Limit));
      qv   <= scaled[QBits-1:0];
    end
    if (cmd.div2) begin
      est <= SINE_BITS'(recip_prod >> QBits);
    end
    if (cmd.div3) begin
      estf <= QBits'(est) * QBits'(FADE_LEN);
    end
    if (cmd.div4) begin
      quot <= (div_rem >= QBits'(FADE_LEN)) ? (est + SINE_BITS'(1)) : est;
    end
    if (cmd.load) begin
      if (active) begin
        sample  <= neg ? (SAMPLE_W'(0) - {1'b0, mag}) : {1'b0, mag};
        playing <= 1'b1;
        last    <= fin;
      end else begin
        sample  <= '0;
        playing <= 1'b0;
        last    <= 1'b0;
      end
    end
  end

  a_last_ends_tone: assert property (@(posedge clk) disable iff (rst)
    cmd.load && active && fin |=> !active && last && playing)
    else $error("final sample did not end the tone");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (sample != 16'h8000))
    else $error("sample outside the symmetric range");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    cmd.load && !active |=> (sample == '0) && !last)
    else $error("idle sample is not silent");

endmodule

### src/earcon_tone_generator.sv
// A tick request that plays a tone passes the two multiply and four divide steps of the
// datapath and then the output step, where its sample is registered once the output is free;
// a tick request while idle goes straight to the output step, and a start request gives none.
// A new request is taken only when the block is back in its idle state after the last one.
// Reset (rst, synchronous) leaves the block idle with phase, length and gain cleared.
module earcon_tone_generator
  import etg_pkg::*;
#(
  parameter int SAMPLE_RATE     = 44100,
  parameter int FADE_LEN        = 220,
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // category [1:0], volume [18:2]
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // sample [15:0]
  output logic        m_axis_tuser,   // playing
  output logic        m_axis_tlast
);

  etg_cmd_t    cmd;
  etg_status_t status;

  etg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_kind   (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  etg_datapath #(
    .SAMPLE_RATE     (SAMPLE_RATE),
    .FADE_LEN        (FADE_LEN),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .PHASE_BITS      (PHASE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .category (s_axis_tdata[1:0]),
    .volume   (s_axis_tdata[18:2]),
    .status   (status),
    .sample   (m_axis_tdata),
    .playing  (m_axis_tuser),
    .last     (m_axis_tlast)
  );

endmodule

### verif/etg_checker.sv
`timescale 1ns / 1ps

module etg_checker
  import etg_pkg::*;
#(
  parameter int SAMPLE_RATE     = 44100,
  parameter int FADE_LEN        = 220,
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // category [1:0], volume [18:2]
  input  logic        s_axis_tuser,   // cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // sample [15:0]
  input  logic        m_axis_tuser,   // playing
  input  logic        m_axis_tlast,
  output int          errors,
  output int          pending,
  output int          samples,
  output int          tones_done
);

  localparam int TABLE_LEN = 1 << SINE_TABLE_BITS;
  localparam int QUARTER   = TABLE_LEN / 4;

  typedef struct packed {
    logic [15:0] sample;
    logic        playing;
    logic        last;
  } tone_sample_t;

  tone_sample_t      expected_q[$];
  logic signed [15:0] sine_rom [TABLE_LEN];

  logic                  tone_on;
  logic [IDX_BITS-1:0]   pos;
  logic [IDX_BITS-1:0]   len;
  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] step;
  logic [VOL_BITS-1:0]   gain;

  function automatic int quarter_sine(int q);
    longint x, x2, term, sum, v;
    x = longint'(q) * HALF_PI_Q30 / QUARTER;
    x2 = (x * x) >>> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >>> 30) / (2 * n * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
    if (v > 32767) begin
      v = 32767;
    end
    return int'(v);
  endfunction

  initial begin : build_sine_rom
    int quad, r, v;
    for (int k = 0; k < TABLE_LEN; k++) begin
      quad = k / QUARTER;
      r = k % QUARTER;
      if (quad == 0 || quad == 2) begin
        v = quarter_sine(r);
      end else begin
        v = quarter_sine(QUARTER - r);
      end
      if (quad >= 2) begin
        v = -v;
      end
      sine_rom[k] = 16'(v);
    end
  end

  task automatic start_tone(input logic [1:0] cat, input logic [VOL_BITS-1:0] vol);
    longint unsigned freq, ms, total, inc;
    case (cat)
      CAT_OPPORTUNITY: begin
        freq = 660;
        ms = 110;
      end
      CAT_WARNING: begin
        freq = 880;
        ms = 140;
      end
      default: begin
        freq = 440;
        ms = 80;
      end
    endcase
    total = SAMPLE_RATE * ms / 1000;
    if (total > TOTAL_MAX) begin
      total = TOTAL_MAX;
    end
    inc = ((freq << PHASE_BITS) + SAMPLE_RATE / 2) / SAMPLE_RATE;
    gain = (vol > FULL_GAIN) ? FULL_GAIN : vol;
    phase = '0;
    pos = '0;
    len = total[IDX_BITS-1:0];
    step = inc[PHASE_BITS-1:0];
    tone_on = (gain != 0) && (total != 0);
  endtask

  function automatic tone_sample_t next_sample();
    tone_sample_t    r;
    logic signed [15:0] s;
    logic [15:0]     amp;
    int unsigned     rem, env;
    longint unsigned wide, mag;
    r = '0;
    if (tone_on) begin
      s = sine_rom[phase[PHASE_BITS-1 -: SINE_TABLE_BITS]];
      rem = (pos < len) ? len - 1 - pos : 0;
      env = pos;
      if (rem < env) begin
        env = rem;
      end
      if (env > FADE_LEN) begin
        env = FADE_LEN;
      end
      amp = (s < 0) ? -s : s;
      wide = amp;
      mag = wide * env * gain * TONE_SCALE / (FADE_LEN * 65536);
      if (mag > SAMPLE_MAX) begin
        mag = SAMPLE_MAX;
      end
      r.sample = (s < 0) ? -mag[15:0] : mag[15:0];
      r.playing = 1'b1;
      phase = phase + step;
      pos = pos + 1'b1;
      r.last = (pos >= len);
      if (r.last) begin
        tone_on = 1'b0;
      end
    end
    return r;
  endfunction

  // Results are checked before requests so that a sample can never be matched against
  // an expectation that was queued on the same edge.
  always @(posedge clk) begin : monitor
    tone_sample_t want, got;
    if (rst) begin
      expected_q.delete();
      tone_on = 1'b0;
      pos = '0;
      len = '0;
      phase = '0;
      step = '0;
      gain = '0;
      errors = 0;
      samples = 0;
      tones_done = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.sample = m_axis_tdata;
        got.playing = m_axis_tuser;
        got.last = m_axis_tlast;
        samples++;
        if (got.last) begin
          tones_done++;
        end
        if (expected_q.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: unexpected sample %0d playing %b last %b", $realtime,
                     $signed(got.sample), got.playing, got.last);
          end
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (errors < 10) begin
              $display("%0t: sample %0d playing %b last %b, expected %0d %b %b",
                       $realtime, $signed(got.sample), got.playing, got.last,
                       $signed(want.sample), want.playing, want.last);
            end
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CMD_START) begin
          start_tone(s_axis_tdata[1:0], s_axis_tdata[18:2]);
        end else begin
          want = next_sample();
          expected_q.push_back(want);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import etg_pkg::*;

  localparam logic [1:0] CAT_SPARE       = 2'd3;
  localparam int         CYCLE_LIMIT     = 4_000_000;
  localparam int         RANDOM_REQUESTS = 600;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int errors;
  int pending;
  int samples;
  int tones_done;
  int requests = 0;
  int ticks = 0;
  int cycles = 0;

  earcon_tone_generator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  etg_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .errors        (errors),
    .pending       (pending),
    .samples       (samples),
    .tones_done    (tones_done)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r < 8) begin
      return 0;
    end else if (r < 14) begin
      return $urandom_range(1, 3);
    end else if (r == 14) begin
      return $urandom_range(4, 8);
    end
    return $urandom_range(10, 25);
  endfunction

  function automatic logic [VOL_BITS-1:0] pick_volume();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 17'($urandom_range(65537, 131071));
      2: return FULL_GAIN;
      3: return 17'($urandom_range(1, 255));
      default: return 17'($urandom_range(1, 65536));
    endcase
  endfunction

  task automatic send_request(input logic cmd, input logic [1:0] cat,
                              input logic [VOL_BITS-1:0] vol);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {5'd0, vol, cat};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    requests++;
    if (cmd == CMD_TICK) begin
      ticks++;
    end
  endtask

  task automatic request_sample();
    send_request(CMD_TICK, 2'($urandom_range(0, 3)), 17'($urandom));
  endtask

  initial begin : sink
    int gap;
    m_axis_tready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin : source
    int n, burst;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= CMD_TICK;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    request_sample();
    send_request(CMD_START, CAT_DEFAULT, FULL_GAIN);
    repeat (3) request_sample();
    send_request(CMD_START, CAT_SPARE, 17'h1FFFF);
    repeat (2) request_sample();
    send_request(CMD_START, CAT_OPPORTUNITY, 17'd1);
    repeat (2) request_sample();
    send_request(CMD_START, CAT_WARNING, 17'd65535);
    repeat (2) request_sample();
    send_request(CMD_START, CAT_DEFAULT, 17'd0);
    request_sample();
    send_request(CMD_START, CAT_WARNING, 17'd65537);
    request_sample();
    send_request(CMD_START, CAT_OPPORTUNITY, 17'd0);
    request_sample();

    n = 0;
    while (n < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          send_request(CMD_START, 2'($urandom_range(0, 3)), '0);
        end else begin
          request_sample();
        end
        n++;
      end else begin
        burst = $urandom_range(1, 40);
        send_request(CMD_START, 2'($urandom_range(0, 3)), pick_volume());
        repeat (burst) request_sample();
        n += burst + 1;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d requests (%0d ticks); checked %0d samples.", requests, ticks, samples);
    $display("Starts covered every category, zero and saturating volumes and restarts; %0d %s",
             tones_done, "final samples were seen.");
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
src/etg_pkg.sv
src/etg_ctrl.sv
src/etg_datapath.sv
src/earcon_tone_generator.sv
verif/etg_checker.sv
verif/tb.sv
